// ===== design/fdr_pkg.sv =====
// ---------------------------------------------------------------------------
// fdr_pkg: shared types and constants of the frame delay regulator
// Field widths, register reset values, register indexes, FSM states.
// ---------------------------------------------------------------------------
`default_nettype none

package fdr_pkg;

  // Field widths
  localparam int MEAS_W     = 24;  // intervals and delays, 1/256 ms
  localparam int GAIN_W     = 16;  // loop gain, Q8.8
  localparam int STEP_W     = 16;  // integration step, Q0.16
  localparam int RATE_W     = 32;  // signed delay rate
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // Serial multiplier: accumulator wide enough for bracket * step
  localparam int MUL_W = 16;  // serial operand width (gain or step)
  localparam int ACC_W = 74;

  // Default ring depth
  localparam int HISTORY_DEPTH_DEF = 16;

  // Register reset values
  localparam logic [MEAS_W-1:0] TARGET_RST = MEAS_W'(21333);
  localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(1280);
  localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(5461);
  localparam logic [MEAS_W-1:0] MIN_RST    = MEAS_W'(256);
  localparam logic [RATE_W-1:0] RATE_RST   = RATE_W'(2560);

  // Rate saturation bounds
  localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = CFG_IDX_W'(3);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_MUL_X,
    ST_WAIT_X,
    ST_MUL_BR,
    ST_WAIT_BR,
    ST_MUL_RT,
    ST_WAIT_RT,
    ST_MUL_INC,
    ST_WAIT_INC,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== design/fdr_ram.sv =====
// ---------------------------------------------------------------------------
// fdr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fdr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/fdr_sermul.sv =====
// ---------------------------------------------------------------------------
// fdr_sermul: bit-serial shift-add multiplier
// Signed multiplicand times unsigned serial operand, one operand bit per
// cycle, added onto a preset accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module fdr_sermul #(
  parameter int AW_ACC = fdr_pkg::ACC_W,
  parameter int MPL_W  = fdr_pkg::MUL_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [AW_ACC-1:0] mcand_i,   // signed, two's complement
  input  wire logic [MPL_W-1:0]  mplier_i,  // unsigned
  input  wire logic [AW_ACC-1:0] init_i,    // accumulator preset
  output logic      [AW_ACC-1:0] acc_o,
  output logic                   busy_o
);

  import fdr_pkg::*;

  localparam int CNT_W = $clog2(MPL_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [AW_ACC-1:0] acc_q, acc_d;
  logic [AW_ACC-1:0] mcand_q, mcand_d;
  logic [MPL_W-1:0]  mplier_q, mplier_d;

  // one partial product per cycle, multiplicand moves left
  always_comb begin
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (start_i) begin
      cnt_d    = CNT_W'(MPL_W);
      acc_d    = init_i;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
    end else if (cnt_q != '0) begin
      cnt_d    = cnt_q - CNT_W'(1);
      acc_d    = mplier_q[0] ? acc_q + mcand_q : acc_q;
      mcand_d  = {mcand_q[AW_ACC-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[MPL_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = (cnt_q != '0);

endmodule

`default_nettype wire

// ===== design/frame_delay_regulator_core.sv =====
// ---------------------------------------------------------------------------
// frame_delay_regulator_core: frame delay regulation loop
// Keeps a ring of recent frame intervals, its mean, and a damped
// second-order loop that turns the mean's error into the next frame delay.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one measured frame interval per transaction; m_axis returns
//   one frame delay per input transaction, in the same order.
//   cfg writes target, gain, step and floor; it is ready only while the block
//   is idle, and indexes beyond the register list are dropped.
//   Processing: each input runs through the bit-serial mean divider (one
//   quotient bit per cycle, SUM_W = 24 + log2(depth) bits) and through four
//   passes over the 16-bit operand of the shared bit-serial multiplier. One
//   item is in work at a time: no new input is taken until the sequencer has
//   handed the last result to the output register.
//   The result sits in an output register; the next input is taken while it
//   waits. A stalled receiver holds the finished result in the sequencer
//   until the output register drains.
//   Reset: registers take their defaults, rate 2560, delay = default target.
//   Ring entries read as the default target until first written, tracked by
//   one valid flop per entry, so no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module frame_delay_regulator_core #(
  parameter int HISTORY_DEPTH = fdr_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [fdr_pkg::MEAS_W-1:0]     s_axis_tdata_i,  // [23:0] measured_interval
  // output stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic      [fdr_pkg::MEAS_W-1:0]     m_axis_tdata_o,  // [23:0] frame_delay
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fdr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fdr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import fdr_pkg::*;

  localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W  = MEAS_W + $clog2(HISTORY_DEPTH);
  localparam int REM_W  = $clog2(HISTORY_DEPTH) + 1;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int D_W    = RATE_W + 2;

  localparam logic [SUM_W-1:0] SUM_RST  = SUM_W'(HISTORY_DEPTH * TARGET_RST);
  localparam logic [AW-1:0]    PTR_RST  = AW'(1 % HISTORY_DEPTH);
  localparam logic [AW-1:0]    PTR_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [REM_W:0]   DEPTH_C  = (REM_W + 1)'(HISTORY_DEPTH);

  // configuration registers
  logic [MEAS_W-1:0] target_q;
  logic [GAIN_W-1:0] gain_q;
  logic [STEP_W-1:0] step_q;
  logic [MEAS_W-1:0] min_q;

  // loop state
  logic [HISTORY_DEPTH-1:0] valid_q;
  logic [AW-1:0]            ptr_q;
  logic [SUM_W-1:0]         sum_q;
  logic [RATE_W-1:0]        rate_q;
  logic [MEAS_W-1:0]        cur_q;
  logic [MEAS_W-1:0]        meas_q;

  // divider
  logic [SUM_W-1:0]  div_q, div_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DCNT_W-1:0] dcnt_q;
  logic [REM_W:0]    trial;
  logic              qbit;

  // output register
  logic              m_valid_q;
  logic [MEAS_W-1:0] m_data_q;

  // sequencer
  state_e state_q, state_d;

  // sequencer strobes
  logic s_accept, cfg_write, out_free;
  logic ram_re, ram_we, div_load, div_step, mul_start, rate_load, cur_load, out_load;

  // ring memory and multiplier
  logic [MEAS_W-1:0] ram_rdata;
  logic [MEAS_W-1:0] old_val;
  logic [SUM_W-1:0]  sum_new;
  logic [ACC_W-1:0]  mul_mcand, mul_init, mul_acc;
  logic [MUL_W-1:0]  mul_mplier;
  logic              mul_busy;

  // arithmetic
  logic [MEAS_W-1:0]          mean;
  logic [MEAS_W:0]            diff;
  logic [RATE_W+8:0]          rate_sh;
  logic [ACC_W-RATE_W-32:0]   rate_hi;
  logic                       rate_fits;
  logic [RATE_W-1:0]          rate_new;
  logic [RATE_W-1:0]          inc;
  logic signed [D_W-1:0]      dsum, dmax, dmin, dsat, dflr;

  assign s_accept  = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_write = cfg_valid_i & cfg_ready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (s_axis_tvalid_i) state_d = ST_READ;
      ST_READ:     state_d = ST_DIV;
      ST_DIV:      if (dcnt_q == '0) state_d = ST_MUL_X;
      ST_MUL_X:    state_d = ST_WAIT_X;
      ST_WAIT_X:   if (!mul_busy) state_d = ST_MUL_BR;
      ST_MUL_BR:   state_d = ST_WAIT_BR;
      ST_WAIT_BR:  if (!mul_busy) state_d = ST_MUL_RT;
      ST_MUL_RT:   state_d = ST_WAIT_RT;
      ST_WAIT_RT:  if (!mul_busy) state_d = ST_MUL_INC;
      ST_MUL_INC:  state_d = ST_WAIT_INC;
      ST_WAIT_INC: if (!mul_busy) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    s_axis_tready_o = 1'b0;
    cfg_ready_o     = 1'b0;
    ram_re          = 1'b0;
    ram_we          = 1'b0;
    div_load        = 1'b0;
    div_step        = 1'b0;
    mul_start       = 1'b0;
    rate_load       = 1'b0;
    cur_load        = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cfg_ready_o     = 1'b1;
        ram_re          = s_axis_tvalid_i;
      end
      ST_READ: begin
        ram_we   = 1'b1;
        div_load = 1'b1;
      end
      ST_DIV:      div_step  = (dcnt_q != '0);
      ST_MUL_X:    mul_start = 1'b1;
      ST_MUL_BR:   mul_start = 1'b1;
      ST_MUL_RT:   mul_start = 1'b1;
      ST_MUL_INC:  mul_start = 1'b1;
      ST_WAIT_RT:  rate_load = !mul_busy;
      ST_WAIT_INC: cur_load  = !mul_busy;
      ST_OUT:      out_load  = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      gain_q   <= GAIN_RST;
      step_q   <= STEP_RST;
      min_q    <= MIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_TARGET: target_q <= cfg_data_i[MEAS_W-1:0];
        CFG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_STEP:   step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_MIN:    min_q    <= cfg_data_i[MEAS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- interval ring ----------------
  fdr_ram #(
    .WIDTH (MEAS_W),
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (meas_q),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // entry never written reads as the default target
  assign old_val = valid_q[ptr_q] ? ram_rdata : TARGET_RST;
  assign sum_new = sum_q - {{(SUM_W-MEAS_W){1'b0}}, old_val}
                         + {{(SUM_W-MEAS_W){1'b0}}, meas_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= PTR_RST;
      sum_q   <= SUM_RST;
    end else if (ram_we) begin
      valid_q[ptr_q] <= 1'b1;
      ptr_q          <= (ptr_q == PTR_LAST) ? '0 : ptr_q + AW'(1);
      sum_q          <= sum_new;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      meas_q <= s_axis_tdata_i;
    end
  end

  // ---------------- mean: restoring division by the depth ----------------
  assign trial = {rem_q, div_q[SUM_W-1]};
  assign qbit  = (trial >= DEPTH_C);

  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    if (div_load) begin
      div_d = sum_new;
      rem_d = '0;
    end else if (div_step) begin
      div_d = {div_q[SUM_W-2:0], qbit};
      rem_d = qbit ? REM_W'(trial - DEPTH_C) : trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (div_load) begin
      dcnt_q <= DCNT_W'(SUM_W);
    end else if (div_step) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign mean = div_q[MEAS_W-1:0];

  // ---------------- multiplier operands ----------------
  // X = g*(T - mean) - 512*rate ; bracket = g*X ; rate = bracket*dt >> 32
  assign diff    = {1'b0, target_q} - {1'b0, mean};
  assign rate_sh = {rate_q, 9'b0};

  always_comb begin
    mul_mcand  = '0;
    mul_mplier = '0;
    mul_init   = '0;
    unique case (state_q)
      ST_MUL_X: begin
        mul_mcand  = {{(ACC_W-MEAS_W-1){diff[MEAS_W]}}, diff};
        mul_mplier = MUL_W'(gain_q);
        mul_init   = '0 - {{(ACC_W-RATE_W-9){rate_sh[RATE_W+8]}}, rate_sh};
      end
      ST_MUL_BR: begin
        mul_mcand  = mul_acc;
        mul_mplier = MUL_W'(gain_q);
      end
      ST_MUL_RT: begin
        mul_mcand  = mul_acc;
        mul_mplier = MUL_W'(step_q);
      end
      ST_MUL_INC: begin
        mul_mcand  = {{(ACC_W-RATE_W){rate_q[RATE_W-1]}}, rate_q};
        mul_mplier = MUL_W'(step_q);
      end
      default: begin
      end
    endcase
  end

  fdr_sermul #(
    .AW_ACC (ACC_W),
    .MPL_W  (MUL_W)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .init_i   (mul_init),
    .acc_o    (mul_acc),
    .busy_o   (mul_busy)
  );

  // ---------------- rate: floor shift by 32 with saturation ----------------
  // the shifted value fits when every bit from the rate's sign bit up agrees
  assign rate_hi   = mul_acc[ACC_W-1:RATE_W+31];
  assign rate_fits = (&rate_hi) | ~(|rate_hi);
  assign rate_new  = rate_fits ? mul_acc[RATE_W+31:32]
                   : (mul_acc[ACC_W-1] ? RATE_MIN : RATE_MAX);

  // ---------------- delay: add increment, saturate, then floor ----------------
  assign inc  = mul_acc[RATE_W+STEP_W-1:STEP_W];
  assign dsum = {{(D_W-MEAS_W){1'b0}}, cur_q} + {{(D_W-RATE_W){inc[RATE_W-1]}}, inc};
  assign dmax = {{(D_W-MEAS_W){1'b0}}, {MEAS_W{1'b1}}};
  assign dmin = {{(D_W-MEAS_W){1'b0}}, min_q};
  assign dsat = (dsum > dmax) ? dmax : dsum;
  assign dflr = (dsat < dmin) ? dmin : dsat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RST;
      cur_q  <= TARGET_RST;
    end else begin
      if (rate_load) begin
        rate_q <= rate_new;
      end
      if (cur_load) begin
        cur_q <= dflr[MEAS_W-1:0];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= cur_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // ---------------- assertions ----------------
  // an accepted transaction always starts with the ring read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_READ))
    else $error("accepted transaction did not enter ring read");

  // the multiplier is idle whenever the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mul_busy)
    else $error("multiplier busy while idle");

  // the delay handed out never lies below the floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (cur_q >= min_q))
    else $error("delay below floor");

  // ring pointer stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_LAST)
    else $error("ring pointer out of range");

endmodule

`default_nettype wire
